[rtl/css_pkg.sv]
// Shared types and constants for the charger setpoint supervisor.
// Holds the word structs, register indexes and fixed-point divide constants.
// No dependencies.
`default_nettype none

package css_pkg;

   // Field widths
   localparam int ADC_W       = 12;
   localparam int ADC_BITS    = 12;   // full-scale bits of the rail converter
   localparam int MV_W        = 16;
   localparam int RAIL_W      = 17;   // filter accumulator, millivolts
   localparam int DUTY_W      = 11;
   localparam int FLAG_W      = 7;
   localparam int RATIO_W     = 10;
   localparam int TIME_W      = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Sample scaling: mv = ((adc * 3300) >> ADC_BITS) * 18, saturated to 17 bits
   localparam int SCALE_MV     = 3300;
   localparam int SCALE_PROD_W = ADC_W + 12;
   localparam int SCALE_W      = SCALE_PROD_W - ADC_BITS;
   localparam int SCALED_W     = SCALE_W + 5;
   localparam logic [RAIL_W-1:0] RAIL_MAX = {RAIL_W{1'b1}};

   // Filter and hold
   localparam int SNAP_MV  = 1000;
   localparam int LP_ROUND = 128;
   localparam int ROUND_UP = 49;
   localparam int ROUND_MV = 50;
   localparam int HYST_MV  = 25;

   localparam logic [MV_W-1:0]   DISCHARGE_MV = 16'hffff;
   localparam logic [DUTY_W-1:0] DUTY_FULL    = 11'd1024;

   // Reciprocal constants: floor(n / d) = (n * MUL) >> SHIFT over the ranges used
   localparam int Q50_W         = 12;
   localparam int DIV50_SHIFT   = 23;
   localparam int DIV50_MUL     = 167773;
   localparam int CC_NUM_MUL    = 31;      // 775/3300 reduces to 31/132
   localparam int CC_NUM_W      = 21;
   localparam int CC_A_W        = 14;
   localparam int CC_A_MAX      = 1000;
   localparam int DIV132_SHIFT  = 28;
   localparam int DIV132_MUL    = 2033602;
   localparam int CC_B_W        = 17;
   localparam int DIV125_SHIFT  = 24;
   localparam int DIV125_MUL    = 134218;
   localparam int CV_PROD_W     = MV_W + RATIO_W;
   localparam int CV_Q_W        = 15;
   localparam int DIV3300_SHIFT = 34;
   localparam int DIV3300_MUL   = 5206021;

   // Error flag bit positions
   localparam int FLAG_DISABLED   = 0;
   localparam int FLAG_OFFLINE    = 1;
   localparam int FLAG_OVERCUR    = 2;
   localparam int FLAG_RAIL_OVER  = 3;
   localparam int FLAG_RAIL_UNDER = 4;
   localparam int FLAG_DROP_OVER  = 5;
   localparam int FLAG_TIMEOUT    = 6;

   // Register reset values
   localparam logic [MV_W-1:0]    CURRENT_LIMIT_RST = 16'd3000;
   localparam logic [MV_W-1:0]    MAX_RAIL_RST      = 16'd58000;
   localparam logic [MV_W-1:0]    FUDGE_RST         = 16'd300;
   localparam logic [MV_W-1:0]    MAX_DROP_RST      = 16'd16483;
   localparam logic [RATIO_W-1:0] CV_RATIO_RST      = 10'd205;
   localparam logic [MV_W-1:0]    TIMEOUT_RST       = 16'd5000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CURRENT_LIMIT = 3'd0,
      CSR_MAX_RAIL      = 3'd1,
      CSR_VOLTAGE_FUDGE = 3'd2,
      CSR_MAX_DROP      = 3'd3,
      CSR_CV_RATIO      = 3'd4,
      CSR_CMD_TIMEOUT   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic              command_valid;
      logic [MV_W-1:0]   cmd_target_current;
      logic [MV_W-1:0]   cmd_target_voltage;
      logic              cmd_enable;
      logic [ADC_W-1:0]  adc_sample;
      logic              can_online;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [FLAG_W-1:0] fault_bits;
      logic [MV_W-1:0]   rail_voltage_mv;
      logic [DUTY_W-1:0] cc_duty;
      logic [DUTY_W-1:0] cv_duty;
      logic              output_enable;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/charger_setpoint_supervisor.sv]
// Charger setpoint supervisor: filters the rail sample, holds the command and
// computes CC/CV duties and error flags. Depends on css_pkg.
// Throughput: one word per cycle while rsp_stall is low; rsp_valid is the valid bit of the last stage.
// The rate is set by the eight-stage pipeline; each stage advances whenever the
// stage after it is empty or moving, so bubbles collapse under rsp_stall.
// Reset (synchronous, active high): pipeline empty, registers at their defaults,
// filter, held rail and held command cleared to zero.
`default_nettype none

module charger_setpoint_supervisor (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  css_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output css_pkg::rsp_type                      rsp_data,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [css_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire  [css_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int STAGES = 8;

   // Stage words. Flags accumulate as the word moves down the pipe.
   typedef struct packed {
      logic [css_pkg::ADC_W-1:0]  adc;
      logic                       online;
      logic [css_pkg::TIME_W-1:0] now;
      logic [css_pkg::TIME_W-1:0] last;
      logic [css_pkg::MV_W-1:0]   cur;
      logic [css_pkg::MV_W-1:0]   volt;
      logic                       en_req;
   } s1_type;

   typedef struct packed {
      logic [css_pkg::SCALE_W-1:0]  scaled;
      logic [css_pkg::CC_NUM_W-1:0] cc_n;
      logic [css_pkg::MV_W-1:0]     volt;
      logic [css_pkg::FLAG_W-1:0]   flags;
   } s2_type;

   typedef struct packed {
      logic [css_pkg::RAIL_W-1:0] inst;
      logic [css_pkg::CC_A_W-1:0] cc_a;
      logic [css_pkg::MV_W-1:0]   volt;
      logic [css_pkg::FLAG_W-1:0] flags;
   } s3_type;

   typedef struct packed {
      logic [css_pkg::RAIL_W-1:0] filt;
      logic [css_pkg::CC_B_W-1:0] cc_num;
      logic                       cc_cap;
      logic [css_pkg::MV_W-1:0]   volt;
      logic [css_pkg::FLAG_W-1:0] flags;
   } s4_type;

   typedef struct packed {
      logic [css_pkg::RAIL_W-1:0] filt;
      logic [css_pkg::Q50_W-1:0]  q50;
      logic [css_pkg::DUTY_W-1:0] cc;
      logic [css_pkg::MV_W-1:0]   volt;
      logic [css_pkg::FLAG_W-1:0] flags;
   } s5_type;

   typedef struct packed {
      logic [css_pkg::MV_W-1:0]   rail;
      logic [css_pkg::DUTY_W-1:0] cc;
      logic [css_pkg::MV_W-1:0]   volt;
      logic [css_pkg::FLAG_W-1:0] flags;
   } s6_type;

   typedef struct packed {
      logic [css_pkg::MV_W-1:0]      rail;
      logic [css_pkg::DUTY_W-1:0]    cc;
      logic [css_pkg::CV_PROD_W-1:0] prod;
      logic                          discharge;
      logic                          vfault;
      logic [css_pkg::FLAG_W-1:0]    flags;
   } s7_type;

   // Configuration registers
   logic [css_pkg::MV_W-1:0]    current_limit_ff;
   logic [css_pkg::MV_W-1:0]    max_rail_ff;
   logic [css_pkg::MV_W-1:0]    fudge_ff;
   logic [css_pkg::MV_W-1:0]    max_drop_ff;
   logic [css_pkg::RATIO_W-1:0] cv_ratio_ff;
   logic [css_pkg::MV_W-1:0]    timeout_ff;

   // Loop state
   logic [css_pkg::RAIL_W-1:0] filtered_ff, filtered_in;
   logic [css_pkg::MV_W-1:0]   held_rail_ff, held_rail_in;
   logic [css_pkg::MV_W-1:0]   held_cur_ff;
   logic [css_pkg::MV_W-1:0]   held_volt_ff;
   logic                       held_en_ff;
   logic [css_pkg::TIME_W-1:0] last_cmd_ff;

   // Pipeline control
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] adv;
   logic [STAGES-1:0] load;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   s7_type s7_ff, s7_in;
   css_pkg::rsp_type s8_ff, s8_in;

   // A stage can take a word when it is empty or its word moves on.
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int i = STAGES - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      load[0] = adv[0] && req_valid;
      for (int i = 1; i < STAGES; i++) begin
         load[i] = adv[i] && valid_ff[i-1];
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[STAGES-1];
   assign rsp_data  = s8_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // Configuration writes; indexes past the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         current_limit_ff <= css_pkg::CURRENT_LIMIT_RST;
         max_rail_ff      <= css_pkg::MAX_RAIL_RST;
         fudge_ff         <= css_pkg::FUDGE_RST;
         max_drop_ff      <= css_pkg::MAX_DROP_RST;
         cv_ratio_ff      <= css_pkg::CV_RATIO_RST;
         timeout_ff       <= css_pkg::TIMEOUT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            css_pkg::CSR_CURRENT_LIMIT: current_limit_ff <= csr_data;
            css_pkg::CSR_MAX_RAIL:      max_rail_ff      <= csr_data;
            css_pkg::CSR_VOLTAGE_FUDGE: fudge_ff         <= csr_data;
            css_pkg::CSR_MAX_DROP:      max_drop_ff      <= csr_data;
            css_pkg::CSR_CV_RATIO:      cv_ratio_ff      <= csr_data[css_pkg::RATIO_W-1:0];
            css_pkg::CSR_CMD_TIMEOUT:   timeout_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: latch command at accept, capture the word with the held values
   // ---------------------------------------------------------------------
   always_comb begin
      s1_in.adc    = req_data.adc_sample;
      s1_in.online = req_data.can_online;
      s1_in.now    = req_data.now_ms;
      if (req_data.command_valid) begin
         s1_in.last   = req_data.now_ms;
         s1_in.cur    = req_data.cmd_target_current;
         s1_in.volt   = req_data.cmd_target_voltage;
         s1_in.en_req = req_data.cmd_enable;
      end else begin
         s1_in.last   = last_cmd_ff;
         s1_in.cur    = held_cur_ff;
         s1_in.volt   = held_volt_ff;
         s1_in.en_req = held_en_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_cmd_ff  <= '0;
         held_cur_ff  <= '0;
         held_volt_ff <= '0;
         held_en_ff   <= 1'b0;
      end else if (load[0]) begin
         last_cmd_ff  <= s1_in.last;
         held_cur_ff  <= s1_in.cur;
         held_volt_ff <= s1_in.volt;
         held_en_ff   <= s1_in.en_req;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: scale sample, CC numerator times 31, timeout, link, enable and overcurrent flags
   // ---------------------------------------------------------------------
   logic [css_pkg::SCALE_PROD_W-1:0] scale_prod;
   logic [css_pkg::TIME_W-1:0]       elapsed;

   always_comb begin
      scale_prod = css_pkg::SCALE_PROD_W'(s1_ff.adc)
                 * css_pkg::SCALE_PROD_W'(css_pkg::SCALE_MV);
      elapsed    = s1_ff.now - s1_ff.last;
      s2_in.scaled = css_pkg::SCALE_W'(scale_prod >> css_pkg::ADC_BITS);
      s2_in.cc_n   = css_pkg::CC_NUM_W'(s1_ff.cur) * css_pkg::CC_NUM_W'(css_pkg::CC_NUM_MUL);
      s2_in.volt   = s1_ff.volt;
      s2_in.flags  = '0;
      s2_in.flags[css_pkg::FLAG_DISABLED] = !s1_ff.en_req;
      s2_in.flags[css_pkg::FLAG_OFFLINE]  = !s1_ff.online;
      s2_in.flags[css_pkg::FLAG_OVERCUR]  = s1_ff.cur > current_limit_ff;
      s2_in.flags[css_pkg::FLAG_TIMEOUT]  = elapsed >= css_pkg::TIME_W'(timeout_ff);
   end

   // ---------------------------------------------------------------------
   // Stage 3: times 18 with saturation; CC numerator divided by 132
   // ---------------------------------------------------------------------
   logic [css_pkg::SCALED_W-1:0] scaled18;
   logic [31:0]                  scaled32;
   logic [2*css_pkg::CC_NUM_W-1:0] cc_a_full;

   always_comb begin
      scaled18  = (css_pkg::SCALED_W'(s2_ff.scaled) << 4)
                + (css_pkg::SCALED_W'(s2_ff.scaled) << 1);
      scaled32  = 32'(scaled18);
      cc_a_full = (2*css_pkg::CC_NUM_W)'(s2_ff.cc_n)
                * (2*css_pkg::CC_NUM_W)'(css_pkg::DIV132_MUL);
      s3_in.inst  = (scaled32 > 32'(css_pkg::RAIL_MAX)) ? css_pkg::RAIL_MAX
                                                        : scaled32[css_pkg::RAIL_W-1:0];
      s3_in.cc_a  = cc_a_full[css_pkg::DIV132_SHIFT +: css_pkg::CC_A_W];
      s3_in.volt  = s2_ff.volt;
      s3_in.flags = s2_ff.flags;
   end

   // ---------------------------------------------------------------------
   // Stage 4: low-pass filter, alpha 1/32 in Q8, snap on a large jump
   // ---------------------------------------------------------------------
   logic signed [css_pkg::RAIL_W:0]   diff;
   logic        [css_pkg::RAIL_W:0]   diff_mag;
   logic signed [css_pkg::RAIL_W+3:0] lp_val;
   logic signed [css_pkg::RAIL_W+3:0] lp_shift;
   logic        [css_pkg::RAIL_W:0]   filt_sum;

   always_comb begin
      diff     = $signed({1'b0, s3_ff.inst}) - $signed({1'b0, filtered_ff});
      diff_mag = diff[css_pkg::RAIL_W] ? (css_pkg::RAIL_W+1)'(-diff)
                                       : (css_pkg::RAIL_W+1)'(diff);
      lp_val   = $signed({diff, 3'b000}) + (css_pkg::RAIL_W+4)'(css_pkg::LP_ROUND);
      lp_shift = lp_val >>> 8;
      // two's complement add; the filtered value never leaves 0..RAIL_MAX
      filt_sum = {1'b0, filtered_ff} + lp_shift[css_pkg::RAIL_W:0];
      if (diff_mag > (css_pkg::RAIL_W+1)'(css_pkg::SNAP_MV)) begin
         filtered_in = s3_ff.inst;
      end else begin
         filtered_in = filt_sum[css_pkg::RAIL_W-1:0];
      end
      s4_in.filt   = filtered_in;
      s4_in.cc_cap = s3_ff.cc_a > css_pkg::CC_A_W'(css_pkg::CC_A_MAX);
      s4_in.cc_num = {s3_ff.cc_a[9:0], 7'b0000000};
      s4_in.volt   = s3_ff.volt;
      s4_in.flags  = s3_ff.flags;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filtered_ff <= '0;
      end else if (load[3]) begin
         filtered_ff <= filtered_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: ceil to 50 mV (quotient part); CC duty zero on overcurrent, full when capped, else times 128/125
   // ---------------------------------------------------------------------
   logic [css_pkg::RAIL_W:0]         round_num;
   logic [2*(css_pkg::RAIL_W+1)-1:0] q50_full;
   logic [2*css_pkg::CC_B_W:0]       cc_b_full;
   logic [css_pkg::DUTY_W-1:0]       cc_b;

   always_comb begin
      round_num = (css_pkg::RAIL_W+1)'(s4_ff.filt) + (css_pkg::RAIL_W+1)'(css_pkg::ROUND_UP);
      q50_full  = (2*(css_pkg::RAIL_W+1))'(round_num)
                * (2*(css_pkg::RAIL_W+1))'(css_pkg::DIV50_MUL);
      cc_b_full = (2*css_pkg::CC_B_W+1)'(s4_ff.cc_num)
                * (2*css_pkg::CC_B_W+1)'(css_pkg::DIV125_MUL);
      cc_b      = cc_b_full[css_pkg::DIV125_SHIFT +: css_pkg::DUTY_W];
      s5_in.filt  = s4_ff.filt;
      s5_in.q50   = q50_full[css_pkg::DIV50_SHIFT +: css_pkg::Q50_W];
      if (s4_ff.flags[css_pkg::FLAG_OVERCUR]) begin
         s5_in.cc = '0;
      end else if (s4_ff.cc_cap) begin
         s5_in.cc = css_pkg::DUTY_FULL;
      end else begin
         s5_in.cc = cc_b;
      end
      s5_in.volt  = s4_ff.volt;
      s5_in.flags = s4_ff.flags;
   end

   // ---------------------------------------------------------------------
   // Stage 6: rounded value and 25 mV hysteresis hold
   // ---------------------------------------------------------------------
   logic [css_pkg::RAIL_W:0] round_full;
   logic [css_pkg::MV_W-1:0] rounded;
   logic [css_pkg::RAIL_W:0] held_up;
   logic [css_pkg::RAIL_W:0] filt_up;

   always_comb begin
      round_full = (css_pkg::RAIL_W+1)'(s5_ff.q50) * (css_pkg::RAIL_W+1)'(css_pkg::ROUND_MV);
      rounded    = round_full[css_pkg::MV_W-1:0];
      held_up    = (css_pkg::RAIL_W+1)'(held_rail_ff) + (css_pkg::RAIL_W+1)'(css_pkg::HYST_MV);
      filt_up    = (css_pkg::RAIL_W+1)'(s5_ff.filt) + (css_pkg::RAIL_W+1)'(css_pkg::HYST_MV);
      held_rail_in = held_rail_ff;
      if (rounded > held_rail_ff) begin
         if ((css_pkg::RAIL_W+1)'(s5_ff.filt) > held_up) begin
            held_rail_in = rounded;
         end
      end else if (rounded < held_rail_ff) begin
         if (filt_up < (css_pkg::RAIL_W+1)'(held_rail_ff)) begin
            held_rail_in = rounded;
         end
      end
      s6_in.rail  = held_rail_in;
      s6_in.cc    = s5_ff.cc;
      s6_in.volt  = s5_ff.volt;
      s6_in.flags = s5_ff.flags;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_rail_ff <= '0;
      end else if (load[5]) begin
         held_rail_ff <= held_rail_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 7: voltage checks and drop times cv_ratio
   // ---------------------------------------------------------------------
   logic [css_pkg::MV_W-1:0] fudge_sel;
   logic [css_pkg::MV_W-1:0] avail;
   logic [css_pkg::MV_W-1:0] drop;
   logic                     over_v;
   logic                     under_v;
   logic                     drop_v;
   logic                     discharge;

   always_comb begin
      fudge_sel = (s6_ff.rail < fudge_ff) ? s6_ff.rail : fudge_ff;
      avail     = s6_ff.rail - fudge_sel;
      drop      = avail - s6_ff.volt;
      discharge = s6_ff.volt == css_pkg::DISCHARGE_MV;
      over_v    = s6_ff.rail > max_rail_ff;
      under_v   = !discharge && (s6_ff.volt > avail);
      // a target above the available voltage wraps the drop, so it also counts as drop over
      drop_v    = !discharge && (under_v || (drop > max_drop_ff));
      s7_in.rail      = s6_ff.rail;
      s7_in.cc        = s6_ff.cc;
      s7_in.prod      = css_pkg::CV_PROD_W'(drop) * css_pkg::CV_PROD_W'(cv_ratio_ff);
      s7_in.discharge = discharge;
      s7_in.vfault    = over_v || under_v || drop_v;
      s7_in.flags     = s6_ff.flags;
      s7_in.flags[css_pkg::FLAG_RAIL_OVER]  = over_v;
      s7_in.flags[css_pkg::FLAG_RAIL_UNDER] = under_v;
      s7_in.flags[css_pkg::FLAG_DROP_OVER]  = drop_v;
   end

   // ---------------------------------------------------------------------
   // Stage 8: CV duty = product / 3300, capped; zero on discharge, full on a voltage fault; result word
   // ---------------------------------------------------------------------
   logic [2*css_pkg::CV_PROD_W-1:0] cv_full;
   logic [css_pkg::CV_Q_W-1:0]      cv_q;

   always_comb begin
      cv_full = (2*css_pkg::CV_PROD_W)'(s7_ff.prod)
              * (2*css_pkg::CV_PROD_W)'(css_pkg::DIV3300_MUL);
      cv_q    = cv_full[css_pkg::DIV3300_SHIFT +: css_pkg::CV_Q_W];
      s8_in.fault_bits      = s7_ff.flags;
      s8_in.rail_voltage_mv = s7_ff.rail;
      s8_in.cc_duty         = s7_ff.cc;
      if (s7_ff.discharge) begin
         s8_in.cv_duty = '0;
      end else if (s7_ff.vfault) begin
         s8_in.cv_duty = css_pkg::DUTY_FULL;
      end else if (cv_q > css_pkg::CV_Q_W'(css_pkg::DUTY_FULL)) begin
         s8_in.cv_duty = css_pkg::DUTY_FULL;
      end else begin
         s8_in.cv_duty = cv_q[css_pkg::DUTY_W-1:0];
      end
      s8_in.output_enable = s7_ff.flags == '0;
   end

   // Stage payload registers
   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_ff <= s1_in;
      end
      if (load[1]) begin
         s2_ff <= s2_in;
      end
      if (load[2]) begin
         s3_ff <= s3_in;
      end
      if (load[3]) begin
         s4_ff <= s4_in;
      end
      if (load[4]) begin
         s5_ff <= s5_in;
      end
      if (load[5]) begin
         s6_ff <= s6_in;
      end
      if (load[6]) begin
         s7_ff <= s7_in;
      end
      if (load[7]) begin
         s8_ff <= s8_in;
      end
   end

endmodule

`default_nettype wire
